### src/top_k_interval_region_table_assert.svh
// Assertion macros shared by the checker
`ifndef TOP_K_INTERVAL_REGION_TABLE_ASSERT_SVH
`define TOP_K_INTERVAL_REGION_TABLE_ASSERT_SVH

// a holds -> c holds in the same cycle
`define TKIRT_ASSERT_SAME(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// a holds -> c holds in the next cycle
`define TKIRT_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

### src/tkirt_pkg.sv
package tkirt_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POINT  = 2'd1;
   localparam logic [1:0] OP_RANGE  = 2'd2;
   localparam logic [1:0] OP_TYPE   = 2'd3;

   localparam logic [7:0] CSR_MIN_SIZE    = 8'd0;
   localparam logic [7:0] CSR_MAX_REGIONS = 8'd1;

   localparam logic [4:0] RESULT_CAP      = 5'd16;
   localparam logic [4:0] MAX_REGIONS_RST = 5'd16;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [63:0]        first_instr;
      logic [63:0]        stop_instr;
      logic [63:0]        first_cycle;
      logic [63:0]        stop_cycle;
      logic signed [31:0] importance;
      logic [1:0]         kind;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [4:0]         region_id;
      logic [63:0]        out_start_instr;
      logic [63:0]        out_end_instr;
      logic [63:0]        out_start_cycle;
      logic [63:0]        out_end_cycle;
      logic signed [31:0] out_importance;
      logic [1:0]         out_type;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]         id;
      logic [1:0]         rtype;
      logic signed [31:0] imp;
      logic [63:0]        s_i;
      logic [63:0]        e_i;
      logic [63:0]        s_c;
      logic [63:0]        e_c;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_PUT_OLD, S_OUT, S_LAST
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_issue;
      logic idx_inc;
      logic wr_new;
      logic wr_old;
      logic pend_load;
      logic rsp_pend;
      logic rsp_small;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_point;
      logic too_small;
      logic scan_more;
      logic evicted;
      logic place_before;
      logic match;
      logic pend_vld;
   } sts_type;

   function automatic rsp_type make_rsp(logic h, entry_type en, logic [4:0] cnt, logic lst);
      rsp_type r;
      r.hit             = h;
      r.region_id       = en.id;
      r.out_start_instr = en.s_i;
      r.out_end_instr   = en.e_i;
      r.out_start_cycle = en.s_c;
      r.out_end_cycle   = en.e_c;
      r.out_importance  = en.imp;
      r.out_type        = en.rtype;
      r.entry_count     = cnt;
      r.last            = lst;
      return r;
   endfunction

endpackage

### src/tkirt_ctrl.sv
module tkirt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tkirt_pkg::sts_type sts,
   output tkirt_pkg::cmd_type cmd
);
   import tkirt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            if (sts.is_insert && sts.too_small) state_in = S_LAST;
            else if (sts.scan_more)             state_in = S_EVAL;
            else                                state_in = S_LAST;
         end
         S_EVAL: begin
            if (sts.is_insert) begin
               if (!sts.evicted && sts.place_before) state_in = S_PUT_OLD;
               else                                  state_in = S_READ;
            end else if (sts.match && sts.pend_vld) begin
               state_in = S_OUT;
            end else begin
               state_in = S_READ;
            end
         end
         S_PUT_OLD: state_in = S_READ;
         S_OUT: begin
            if (rsp_ready) state_in = S_READ;
         end
         S_LAST: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_READ: begin
            if (sts.is_insert && sts.too_small) cmd.rsp_small = 1'b1;
            else if (sts.scan_more)             cmd.rd_issue  = 1'b1;
            else                                cmd.fin       = 1'b1;
         end
         S_EVAL: begin
            if (sts.is_insert) begin
               if (sts.evicted) begin
                  cmd.idx_inc = 1'b1;
               end else if (sts.place_before) begin
                  cmd.wr_new = 1'b1;
               end else begin
                  cmd.wr_old  = 1'b1;
                  cmd.idx_inc = 1'b1;
               end
            end else begin
               cmd.idx_inc   = 1'b1;
               cmd.pend_load = sts.match;
               cmd.rsp_pend  = sts.match && sts.pend_vld;
            end
         end
         S_PUT_OLD: begin
            cmd.wr_old  = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         S_OUT:  rsp_valid = 1'b1;
         S_LAST: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

### src/tkirt_dpath.sv
module tkirt_dpath #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  tkirt_pkg::req_type req_data,
   input  logic               csr_valid,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  tkirt_pkg::cmd_type cmd,
   output tkirt_pkg::sts_type sts,
   output tkirt_pkg::rsp_type rsp_data
);
   import tkirt_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   entry_type mem [2][MAX_ENTRIES];

   req_type    req_ff;
   entry_type  rd_ff, pend_ff;
   rsp_type    rsp_ff;
   logic [CW-1:0] count_ff, idx_ff, n_ff;
   logic [4:0]    k_ff;
   logic          bank_ff, placed_ff, kept_ff, pend_vld_ff;
   logic [31:0]   min_ff;
   logic [4:0]    maxr_ff;

   logic [CW-1:0] limit;
   entry_type     nw;
   logic          fin_place, wr_en, new_wr;
   entry_type     wr_data;
   logic [CW-1:0] n_fin;
   logic [64:0]   span_sum;

   always_comb begin
      if (maxr_ff == 5'd0)                       limit = CW'(1);
      else if (int'(maxr_ff) > MAX_ENTRIES)      limit = CW'(MAX_ENTRIES);
      else                                       limit = CW'(maxr_ff);
   end

   always_comb begin
      nw.id    = 5'(count_ff);
      nw.rtype = req_ff.kind;
      nw.imp   = req_ff.importance;
      nw.s_i   = req_ff.first_instr;
      nw.e_i   = req_ff.stop_instr;
      nw.s_c   = req_ff.first_cycle;
      nw.e_c   = req_ff.stop_cycle;
   end

   // new region still unplaced at the end of the scan goes at the tail, if below the limit
   assign fin_place = cmd.fin && (req_ff.opcode == OP_INSERT) && !placed_ff;
   assign new_wr    = cmd.wr_new || fin_place;
   assign wr_en     = (new_wr || cmd.wr_old) && (n_ff < limit);
   assign wr_data   = cmd.wr_old ? rd_ff : nw;
   assign n_fin     = n_ff + CW'(wr_en);
   assign span_sum  = {1'b0, req_ff.first_instr} + {33'd0, min_ff};

   always_comb begin
      sts.is_insert    = (req_ff.opcode == OP_INSERT);
      sts.is_point     = (req_ff.opcode == OP_POINT);
      sts.too_small    = span_sum > {1'b0, req_ff.stop_instr};
      sts.scan_more    = (idx_ff < count_ff) && (k_ff != RESULT_CAP) &&
                         !(sts.is_point && (k_ff != 5'd0));
      sts.evicted      = (rd_ff.s_i <= req_ff.stop_instr) &&
                         (rd_ff.e_i >= req_ff.first_instr) &&
                         (rd_ff.imp < req_ff.importance);
      sts.place_before = !placed_ff && (rd_ff.imp < req_ff.importance);
      sts.pend_vld     = pend_vld_ff;
      case (req_ff.opcode)
         OP_POINT: sts.match = (rd_ff.s_i <= req_ff.first_instr) &&
                               (rd_ff.e_i >= req_ff.first_instr);
         OP_RANGE: sts.match = (rd_ff.s_i <= req_ff.stop_instr) &&
                               (rd_ff.e_i >= req_ff.first_instr);
         OP_TYPE:  sts.match = (rd_ff.rtype == req_ff.kind);
         default:  sts.match = 1'b0;
      endcase
   end

   // ping-pong banks: scan reads one, compaction writes the other
   always_ff @(posedge clock) begin
      if (wr_en) mem[~bank_ff][n_ff[IW-1:0]] <= wr_data;
      if (cmd.rd_issue) rd_ff <= mem[bank_ff][idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
         min_ff   <= '0;
         maxr_ff  <= MAX_REGIONS_RST;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_MIN_SIZE)         min_ff  <= csr_wdata;
            else if (csr_index == CSR_MAX_REGIONS) maxr_ff <= csr_wdata[4:0];
         end
         if (fin_place || (cmd.fin && sts.is_insert)) begin
            count_ff <= n_fin;
            bank_ff  <= ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff      <= req_data;
         idx_ff      <= '0;
         n_ff        <= '0;
         k_ff        <= '0;
         placed_ff   <= 1'b0;
         kept_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (cmd.idx_inc) idx_ff <= idx_ff + CW'(1);
         if (wr_en)       n_ff   <= n_fin;
         if (new_wr) begin
            placed_ff <= 1'b1;
            kept_ff   <= wr_en;
         end
         if (cmd.pend_load) begin
            pend_ff     <= rd_ff;
            pend_vld_ff <= 1'b1;
            k_ff        <= k_ff + 5'd1;
         end
      end
      if (cmd.rsp_small) rsp_ff <= make_rsp(1'b0, nw, 5'(count_ff), 1'b1);
      if (cmd.rsp_pend)  rsp_ff <= make_rsp(1'b1, pend_ff, 5'(count_ff), 1'b0);
      if (cmd.fin) begin
         if (sts.is_insert)
            rsp_ff <= make_rsp(kept_ff || (fin_place && wr_en), nw, 5'(n_fin), 1'b1);
         else if (pend_vld_ff)
            rsp_ff <= make_rsp(1'b1, pend_ff, 5'(count_ff), 1'b1);
         else
            rsp_ff <= make_rsp(1'b0, '0, 5'(count_ff), 1'b1);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### src/top_k_interval_region_table.sv
// An item is accepted, then each stored entry is read and evaluated in turn,
//   then come a closing scan step and the final beat; an insert that lands
//   ahead of a kept entry adds a put step, each query beat before the last
//   adds an output step, and consumer stalls hold the block. One item at a
//   time; a too-small insert skips the scan, point lookup and the 16-beat cap end the scan early.
// Reset (synchronous, active high): table empty, min size 0, limit 16.
module top_k_interval_region_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tkirt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tkirt_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import tkirt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes are never stalled
   assign csr_ready = 1'b1;

   // sequencer: scan, evict/compact, result beats
   tkirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table banks, counters, compares, result register
   tkirt_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

### src/tkirt_checker.sv
`include "top_k_interval_region_table_assert.svh"

module tkirt_checker #(
   parameter int MAX_ENTRIES = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input tkirt_pkg::rsp_type rsp_data
);
   import tkirt_pkg::*;

   `TKIRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat dropped or changed while stalled")
   `TKIRT_ASSERT_SAME(a_one_item, clock, reset, rsp_valid, !req_ready, "new request taken while a result is pending")
   `TKIRT_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `TKIRT_ASSERT_SAME(a_miss_last, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.last && (int'(rsp_data.entry_count) <= MAX_ENTRIES), "miss beat not final or count too large")

endmodule

bind top_k_interval_region_table tkirt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_tkirt_checker (.*);
